>>> sv/sdes_pkg.sv
package sdes_pkg;

  localparam int unsigned KeyW  = 10;
  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] k1;
    logic [ByteW-1:0] k2;
  } subkeys_t;

  localparam logic [3:0] IP_TAB  [8]  = '{4'd1, 4'd5, 4'd2, 4'd0, 4'd3, 4'd7, 4'd4, 4'd6};
  localparam logic [3:0] IPI_TAB [8]  = '{4'd3, 4'd0, 4'd2, 4'd4, 4'd6, 4'd1, 4'd7, 4'd5};
  localparam logic [3:0] EP_TAB  [8]  = '{4'd3, 4'd0, 4'd1, 4'd2, 4'd1, 4'd2, 4'd3, 4'd0};
  localparam logic [3:0] P10_TAB [10] = '{4'd2, 4'd4, 4'd1, 4'd6, 4'd3,
                                          4'd9, 4'd0, 4'd8, 4'd7, 4'd5};
  localparam logic [3:0] P8_TAB  [8]  = '{4'd5, 4'd2, 4'd6, 4'd3, 4'd7, 4'd4, 4'd9, 4'd8};

  localparam logic [1:0] SBOX0 [4][4] = '{'{2'd1, 2'd0, 2'd3, 2'd2},
                                          '{2'd3, 2'd2, 2'd1, 2'd0},
                                          '{2'd0, 2'd2, 2'd1, 2'd3},
                                          '{2'd3, 2'd1, 2'd0, 2'd2}};
  localparam logic [1:0] SBOX1 [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                          '{2'd2, 2'd0, 2'd1, 2'd3},
                                          '{2'd3, 2'd0, 2'd1, 2'd0},
                                          '{2'd2, 2'd1, 2'd0, 2'd3}};

  function automatic logic [ByteW-1:0] ip(logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[IP_TAB[i][2:0]];
    end
    return r;
  endfunction

  function automatic logic [ByteW-1:0] ip_inv(logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[IPI_TAB[i][2:0]];
    end
    return r;
  endfunction

  function automatic logic [ByteW-1:0] ep(logic [NibW-1:0] v);
    logic [ByteW-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[EP_TAB[i][1:0]];
    end
    return r;
  endfunction

  function automatic logic [KeyW-1:0] p10(logic [KeyW-1:0] v);
    logic [KeyW-1:0] r;
    for (int i = 0; i < 10; i++) begin
      r[i] = v[P10_TAB[i]];
    end
    return r;
  endfunction

  function automatic logic [ByteW-1:0] p8(logic [KeyW-1:0] v);
    logic [ByteW-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[P8_TAB[i]];
    end
    return r;
  endfunction

  function automatic logic [4:0] rotl5(logic [4:0] v, int unsigned s);
    logic [9:0] w;
    w = {v, v} << s;
    return w[9:5];
  endfunction

  function automatic logic [NibW-1:0] round_f(logic [NibW-1:0] r, logic [ByteW-1:0] k);
    logic [ByteW-1:0] e;
    logic [1:0]       s0;
    logic [1:0]       s1;
    e  = ep(r) ^ k;
    s0 = SBOX0[{e[0], e[3]}][{e[1], e[2]}];
    s1 = SBOX1[{e[4], e[7]}][{e[5], e[6]}];
    return {s0, s1};
  endfunction

endpackage

>>> sv/sdes_byte_cipher_top.sv
// Simplified DES byte cipher. One byte enters per clock on the slave stream while the
// output side is not stalled, and leaves on the master stream after passing three
// register stages: the initial permutation, the first round with the half swap, and the
// second round with the inverse permutation; a stall holds each full stage in place. A
// key write on the cfg channel is always accepted and the derived subkeys are registered,
// so the new key applies from the next cycle on.
module sdes_byte_cipher_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sdes_pkg::KeyW-1:0]   cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] data_in
  input  logic                        s_axis_tuser,   // [0] opcode
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata    // [7:0] data_out
);

  localparam int unsigned NW = sdes_pkg::NibW;

  sdes_pkg::subkeys_t keys;

  logic          v1_q, v2_q, v3_q;
  logic          v1_d, v2_d, v3_d;
  logic          rdy1, rdy2, rdy3;
  logic          op1_q, op2_q;
  logic [NW-1:0] l1_q, r1_q, l2_q, r2_q;
  logic [NW-1:0] l1_new, l2_new;
  logic [7:0]    p_in;
  logic [7:0]    out_q, out_d;

  assign cfg_ready_o = 1'b1;

  sdes_key_sched u_key (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .keys_o     (keys)
  );

  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  assign v1_d = rdy1 ? s_axis_tvalid : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign p_in = sdes_pkg::ip(s_axis_tdata);

  sdes_round u_round1 (
    .op_i     (op1_q),
    .l_i      (l1_q),
    .r_i      (r1_q),
    .enc_key_i(keys.k1),
    .dec_key_i(keys.k2),
    .l_o      (l1_new)
  );

  sdes_round u_round2 (
    .op_i     (op2_q),
    .l_i      (l2_q),
    .r_i      (r2_q),
    .enc_key_i(keys.k2),
    .dec_key_i(keys.k1),
    .l_o      (l2_new)
  );

  assign out_d = sdes_pkg::ip_inv({l2_new, r2_q});

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      op1_q <= s_axis_tuser;
      l1_q  <= p_in[7:4];
      r1_q  <= p_in[3:0];
    end
    if (rdy2 && v1_q) begin
      op2_q <= op1_q;
      l2_q  <= r1_q;     // swap
      r2_q  <= l1_new;
    end
    if (rdy3 && v2_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> sv/sdes_key_sched.sv
module sdes_key_sched (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [sdes_pkg::KeyW-1:0]  cfg_data_i,
  output sdes_pkg::subkeys_t         keys_o
);

  logic [sdes_pkg::KeyW-1:0] perm_key;
  logic [4:0]                hi1;
  logic [4:0]                lo1;
  sdes_pkg::subkeys_t        keys_d;
  sdes_pkg::subkeys_t        keys_q;

  always_comb begin
    perm_key  = sdes_pkg::p10(cfg_data_i);
    hi1       = sdes_pkg::rotl5(perm_key[9:5], 1);
    lo1       = sdes_pkg::rotl5(perm_key[4:0], 1);
    keys_d.k1 = sdes_pkg::p8({hi1, lo1});
    keys_d.k2 = sdes_pkg::p8({sdes_pkg::rotl5(hi1, 2), sdes_pkg::rotl5(lo1, 2)});
  end

  // key 0 yields all-zero subkeys
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
    end else if (cfg_valid_i) begin
      keys_q <= keys_d;
    end
  end

  assign keys_o = keys_q;

endmodule

>>> sv/sdes_round.sv
module sdes_round (
  input  logic                        op_i,
  input  logic [sdes_pkg::NibW-1:0]   l_i,
  input  logic [sdes_pkg::NibW-1:0]   r_i,
  input  logic [sdes_pkg::ByteW-1:0]  enc_key_i,
  input  logic [sdes_pkg::ByteW-1:0]  dec_key_i,
  output logic [sdes_pkg::NibW-1:0]   l_o
);

  logic [sdes_pkg::ByteW-1:0] key;

  assign key = (op_i == sdes_pkg::OP_DECRYPT) ? dec_key_i : enc_key_i;
  assign l_o = l_i ^ sdes_pkg::round_f(r_i, key);

endmodule

>>> sv/sdes_chk.sv
module sdes_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_ready_o,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed under stall");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("key write refused");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("item did not arrive after three cycles");

endmodule

bind sdes_byte_cipher_top sdes_chk u_sdes_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_ready_o  (cfg_ready_o),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
